// ----- rtl/core/fifo_queue_with_level_stats_top_macros.svh -----
// assertion macros for the level-stats queue
// used by the controller and datapath modules
`ifndef FIFO_QUEUE_WITH_LEVEL_STATS_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_LEVEL_STATS_TOP_MACROS_SVH
// implication checked on every clock edge out of reset
`define FQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/fqls_pkg.sv -----
// shared types and constants for the level-stats queue
// no dependencies
package fqls_pkg;
    localparam int QueueDepth = 64;
    localparam int MaxLevel   = 100;
    localparam int AddrW      = $clog2(QueueDepth);
    localparam int CountW     = $clog2(QueueDepth + 1);
    localparam int IdW        = 31;
    localparam int LevelW     = 7;
    localparam int SumW       = 13;
    localparam int AvgW       = 15;
    localparam int DivW       = SumW + 8;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_PEEK    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture request and apply enqueue update
        logic read_head;   // issue ram read at head
        logic take_head;   // latch ram data as head record
        logic scan_start;  // start highest-level scan
        logic scan_read;   // issue scan read
        logic scan_take;   // compare scan data
        logic div_start;
        logic div_step;
    } fqls_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_head;  // dequeue or peek on non-empty queue
        logic scan_more;   // scan entries left to read
        logic div_done;
    } fqls_sts_t;
endpackage

// ----- rtl/core/fqls_ram.sv -----
// generic single-port-write, single-read ram with registered read
// no dependencies
module fqls_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- rtl/core/fqls_datapath.sv -----
// queue pointers, record memory, level scan and average divider
// depends on fqls_pkg, fqls_ram and the macros header
`include "fifo_queue_with_level_stats_top_macros.svh"
module fqls_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fqls_pkg::fqls_cmd_t       cmd,
    output fqls_pkg::fqls_sts_t       sts,
    input  logic [1:0]                s_operation,
    input  logic [fqls_pkg::IdW-1:0]  s_player_id,
    input  logic [fqls_pkg::LevelW-1:0] s_player_level,
    output logic [1:0]                r_status,
    output logic [fqls_pkg::IdW-1:0]  r_out_id,
    output logic [fqls_pkg::LevelW-1:0] r_out_level,
    output logic [fqls_pkg::CountW-1:0] r_entry_count,
    output logic [fqls_pkg::SumW-1:0] r_level_sum,
    output logic [fqls_pkg::AvgW-1:0] r_mean_level,
    output logic [fqls_pkg::IdW-1:0]  r_top_id,
    output logic [fqls_pkg::LevelW-1:0] r_top_level
);
    localparam int AW = fqls_pkg::AddrW;
    localparam int CW = fqls_pkg::CountW;
    localparam int DW = fqls_pkg::DivW;

    logic [AW-1:0] head_reg, tail_reg, head_next, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [fqls_pkg::SumW-1:0] sum_reg, sum_next;
    logic [1:0] op_reg;
    logic [1:0] status_reg, status_next;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] scan_ptr_reg;
    logic [CW-1:0] scan_left_reg;
    logic [fqls_pkg::IdW-1:0] id_rd, out_id_reg, top_id_reg;
    logic [fqls_pkg::LevelW-1:0] lvl_rd, out_lvl_reg, top_lvl_reg;
    logic scan_first_reg;
    logic wr_en;
    logic rec_bad, is_full, is_empty;
    logic [DW-1:0] quot_reg;
    logic [CW:0] rem_reg;
    logic [4:0] div_cnt_reg;
    logic [CW:0] rem_shift;

    assign rec_bad  = (s_player_id == '0) || (s_player_level == '0)
                   || (s_player_level > fqls_pkg::LevelW'(fqls_pkg::MaxLevel));
    assign is_full  = count_reg == CW'(fqls_pkg::QueueDepth);
    assign is_empty = count_reg == '0;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        bump = (p == AW'(fqls_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    // enqueue applied at load, dequeue applied at take_head
    always_comb begin
        status_next = fqls_pkg::ST_OK;
        wr_en = 1'b0;
        tail_next = tail_reg;
        count_next = count_reg;
        sum_next = sum_reg;
        head_next = head_reg;
        if (cmd.load) begin
            if (s_operation == fqls_pkg::OP_ENQUEUE) begin
                if (rec_bad) begin
                    status_next = fqls_pkg::ST_INVALID;
                end else if (is_full) begin
                    status_next = fqls_pkg::ST_FULL;
                end else begin
                    wr_en = 1'b1;
                    tail_next = bump(tail_reg);
                    count_next = count_reg + 1'b1;
                    sum_next = sum_reg + fqls_pkg::SumW'(s_player_level);
                end
            end else if (s_operation == fqls_pkg::OP_DEQUEUE
                      || s_operation == fqls_pkg::OP_PEEK) begin
                if (is_empty) begin
                    status_next = fqls_pkg::ST_EMPTY;
                end
            end
        end
        if (cmd.take_head && op_reg == fqls_pkg::OP_DEQUEUE) begin
            head_next = bump(head_reg);
            count_next = count_reg - 1'b1;
            sum_next = sum_reg - fqls_pkg::SumW'(lvl_rd);
        end
    end

    assign rd_addr = cmd.read_head ? head_reg : scan_ptr_reg;

    fqls_ram #(.Width(fqls_pkg::IdW), .Depth(fqls_pkg::QueueDepth)) u_id_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(tail_reg), .wr_data(s_player_id),
        .rd_addr(rd_addr), .rd_data(id_rd)
    );
    fqls_ram #(.Width(fqls_pkg::LevelW), .Depth(fqls_pkg::QueueDepth)) u_lvl_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(tail_reg), .wr_data(s_player_level),
        .rd_addr(rd_addr), .rd_data(lvl_rd)
    );

    assign rem_shift = {rem_reg[CW-1:0], quot_reg[DW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            sum_reg <= '0;
            op_reg <= fqls_pkg::OP_ENQUEUE;
            scan_left_reg <= '0;
            div_cnt_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            sum_reg <= sum_next;
            if (cmd.load) begin
                op_reg <= s_operation;
                status_reg <= status_next;
                out_id_reg <= '0;
                out_lvl_reg <= '0;
            end
            if (cmd.take_head) begin
                out_id_reg <= id_rd;
                out_lvl_reg <= lvl_rd;
            end
            // scan covers the queue as left after this transfer
            if (cmd.scan_start) begin
                scan_ptr_reg <= head_next;
                scan_left_reg <= count_next;
                scan_first_reg <= 1'b1;
                top_id_reg <= '0;
                top_lvl_reg <= '0;
            end
            if (cmd.scan_read) begin
                scan_ptr_reg <= bump(scan_ptr_reg);
                scan_left_reg <= scan_left_reg - 1'b1;
            end
            if (cmd.scan_take) begin
                scan_first_reg <= 1'b0;
                if (scan_first_reg || lvl_rd > top_lvl_reg) begin
                    top_lvl_reg <= lvl_rd;
                    top_id_reg <= id_rd;
                end
            end
            // restoring division, one quotient bit per cycle
            if (cmd.div_start) begin
                quot_reg <= {sum_reg, 8'd0};
                rem_reg <= '0;
                div_cnt_reg <= 5'(DW);
            end
            if (cmd.div_step) begin
                if (rem_shift >= {1'b0, count_reg}) begin
                    rem_reg <= rem_shift - {1'b0, count_reg};
                    quot_reg <= {quot_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    quot_reg <= {quot_reg[DW-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end
    end

    assign sts.needs_head = (op_reg == fqls_pkg::OP_DEQUEUE || op_reg == fqls_pkg::OP_PEEK)
                         && status_reg == fqls_pkg::ST_OK;
    assign sts.scan_more = scan_left_reg != '0;
    assign sts.div_done = div_cnt_reg == '0;

    assign r_status = status_reg;
    assign r_out_id = out_id_reg;
    assign r_out_level = out_lvl_reg;
    assign r_entry_count = count_reg;
    assign r_level_sum = sum_reg;
    assign r_mean_level = is_empty ? '0 : quot_reg[fqls_pkg::AvgW-1:0];
    assign r_top_id = top_id_reg;
    assign r_top_level = top_lvl_reg;

    `FQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CW'(fqls_pkg::QueueDepth), "count above depth")
    `FQ_ASSERT_IMP(a_empty_sum, aclk, aresetn, count_reg == '0,
        sum_reg == '0, "nonzero sum with empty queue")
    `FQ_ASSERT_NEXT(a_enq_count, aclk, aresetn, wr_en,
        count_reg == $past(count_reg) + 1'b1, "enqueue did not bump count")
endmodule

// ----- rtl/core/fqls_ctrl.sv -----
// sequencer: accept, head read, scan, divide, deliver
// depends on fqls_pkg and the macros header
`include "fifo_queue_with_level_stats_top_macros.svh"
module fqls_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output fqls_pkg::fqls_cmd_t cmd,
    input  fqls_pkg::fqls_sts_t sts
);
    typedef enum logic [2:0] {
        IDLE, HEAD_RD, HEAD_TK, SCAN_RD, SCAN_TK, DIV, DONE
    } state_t;

    state_t state_reg;
    logic div_go_reg;

    assign s_ready = state_reg == IDLE;
    assign m_valid = state_reg == DONE;

    always_comb begin
        cmd = '0;
        cmd.load = s_valid && s_ready;
        cmd.read_head = state_reg == HEAD_RD;
        cmd.take_head = state_reg == HEAD_TK;
        cmd.scan_start = state_reg == HEAD_TK || (state_reg == HEAD_RD && !sts.needs_head);
        cmd.scan_read = state_reg == SCAN_RD && sts.scan_more;
        cmd.scan_take = state_reg == SCAN_TK;
        cmd.div_start = state_reg == DIV && div_go_reg;
        cmd.div_step = state_reg == DIV && !div_go_reg && !sts.div_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            div_go_reg <= 1'b0;
        end else begin
            case (state_reg)
                IDLE: if (s_valid) state_reg <= HEAD_RD;
                HEAD_RD: state_reg <= sts.needs_head ? HEAD_TK : SCAN_RD;
                HEAD_TK: state_reg <= SCAN_RD;
                SCAN_RD: begin
                    if (sts.scan_more) begin
                        state_reg <= SCAN_TK;
                    end else begin
                        state_reg <= DIV;
                        div_go_reg <= 1'b1;
                    end
                end
                SCAN_TK: state_reg <= SCAN_RD;
                DIV: begin
                    div_go_reg <= 1'b0;
                    if (!div_go_reg && sts.div_done) state_reg <= DONE;
                end
                DONE: if (m_ready) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end

    `FQ_ASSERT_IMP(a_one_side, aclk, aresetn, 1'b1, !(s_ready && m_valid),
        "ready and valid together")
    `FQ_ASSERT_NEXT(a_hold_done, aclk, aresetn, m_valid && !m_ready, m_valid,
        "result dropped before transfer")
    `FQ_ASSERT_IMP(a_cmd_excl, aclk, aresetn, 1'b1,
        $onehot0({cmd.load, cmd.scan_read, cmd.scan_take, cmd.div_step}),
        "overlapping commands")
endmodule

// ----- rtl/core/fifo_queue_with_level_stats_top.sv -----
// channel      | signals                                   | direction
// s_ input     | s_valid s_ready s_operation s_player_*    | in
// m_ result    | m_valid m_ready m_status .. m_top_level   | out
// one item at a time; the time from transfer to result depends on the memory
// scan (a read state and a compare state per held record), the 21-step divider
// and whether the front record is read
// s_ready is low from input transfer until the result transfer
// aresetn is synchronous, active low; queue empties on reset
// top level, depends on fqls_pkg, fqls_ctrl, fqls_datapath
module fifo_queue_with_level_stats_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [30:0] s_player_id,
    input  logic [6:0]  s_player_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [30:0] m_out_id,
    output logic [6:0]  m_out_level,
    output logic [6:0]  m_entry_count,
    output logic [12:0] m_level_sum,
    output logic [14:0] m_mean_level,
    output logic [30:0] m_top_id,
    output logic [6:0]  m_top_level
);
    fqls_pkg::fqls_cmd_t cmd;
    fqls_pkg::fqls_sts_t sts;

    fqls_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    fqls_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_operation(s_operation), .s_player_id(s_player_id),
        .s_player_level(s_player_level),
        .r_status(m_status), .r_out_id(m_out_id), .r_out_level(m_out_level),
        .r_entry_count(m_entry_count), .r_level_sum(m_level_sum),
        .r_mean_level(m_mean_level), .r_top_id(m_top_id),
        .r_top_level(m_top_level)
    );
endmodule
